@@ rtl/bhc_pkg.sv @@
// ============================================================================
// bhc_pkg - shared types, constants and helpers of the B-H curve evaluator
// Fixed-point word types, saturation helpers, status and register codes.
// ============================================================================
`default_nettype none

package bhc_pkg;

    typedef logic signed [63:0] word_t;
    typedef logic        [63:0] uword_t;
    typedef logic signed [47:0] q16_t;

    // Intermediates saturate to plus or minus two to the power of 61.
    localparam word_t CAP     = 64'sh2000_0000_0000_0000;
    localparam word_t NEG_CAP = -64'sh2000_0000_0000_0000;
    localparam word_t ONE     = 64'sh0000_0000_4000_0000;
    localparam word_t OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam word_t OUT_MIN = -64'sh0000_8000_0000_0000;

    typedef enum logic [2:0] {
        ST_LINEAR = 3'd0,
        ST_ZERO   = 3'd1,
        ST_EXTRAP = 3'd2,
        ST_INTERP = 3'd3,
        ST_BELOW  = 3'd4,
        ST_LOADED = 3'd5
    } status_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_TABLE_POINTS = 2'd0,
        CFG_LIN_RELUCT   = 2'd1,
        CFG_LIN_GAIN     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic        [30:0] flux;
        logic signed [47:0] field;
        logic signed [47:0] slope;
    } entry_t;

    typedef struct packed {
        logic       start;
        word_t      a;
        uword_t     b;
        logic [5:0] shift;
    } arith_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } arith_rsp_t;

    function automatic uword_t magn(input word_t x);
        word_t n;
        n = -x;
        return x[63] ? uword_t'(n) : uword_t'(x);
    endfunction

    function automatic word_t clampc(input word_t x);
        word_t y;
        y = x;
        if (y > CAP) y = CAP;
        if (y < NEG_CAP) y = NEG_CAP;
        return y;
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        word_t s;
        s = clampc(a) + clampc(b);
        return clampc(s);
    endfunction

    function automatic q16_t out48(input word_t x);
        word_t y;
        y = x;
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        return y[47:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/bhc_ram.sv @@
// ============================================================================
// bhc_ram - generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module bhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/bhc_mul.sv @@
// ============================================================================
// bhc_mul - bit-serial signed fractional multiplier
// Magnitude product one bit per cycle, then shift, saturation and sign.
// ============================================================================
`default_nettype none

module bhc_mul
    import bhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    localparam logic [5:0] LAST_STEP = 6'd63;

    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [128:0] acc_reg, acc_next;
    uword_t       mcand_reg, mcand_next;
    logic         neg_reg, neg_next;
    logic [5:0]   shift_reg, shift_next;
    word_t        result_reg, result_next;
    logic [64:0]  partial;
    logic [127:0] prod_sh;
    uword_t       mag;

    always_comb
    begin
        partial     = acc_reg[128:64] + (acc_reg[0] ? {1'b0, mcand_reg} : 65'd0);
        prod_sh     = acc_reg[127:0] >> shift_reg;
        mag         = (prod_sh > {64'd0, uword_t'(CAP)}) ? uword_t'(CAP) : prod_sh[63:0];
        busy_next   = busy_reg;
        fin_next    = fin_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        neg_next    = neg_reg;
        shift_next  = shift_reg;
        result_next = result_reg;
        if (req.start)
        begin
            acc_next   = {65'd0, magn(word_t'(req.b))};
            mcand_next = magn(req.a);
            neg_next   = req.a[63] ^ req.b[63];
            shift_next = req.shift;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {1'b0, partial, acc_reg[63:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            result_next = neg_reg ? -word_t'(mag) : word_t'(mag);
            fin_next    = 1'b0;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        neg_reg    <= neg_next;
        shift_reg  <= shift_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

@@ rtl/bhc_div.sv @@
// ============================================================================
// bhc_div - restoring fractional divider
// Computes the scaled quotient one bit per cycle over 128 steps, saturated.
// ============================================================================
`default_nettype none

module bhc_div
    import bhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    localparam logic [6:0] LAST_STEP = 7'd127;

    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] dvd_reg, dvd_next;
    uword_t       rem_reg, rem_next;
    uword_t       q_reg, q_next;
    logic         over_reg, over_next;
    uword_t       d_reg, d_next;
    logic         neg_reg, neg_next;
    word_t        result_reg, result_next;
    uword_t       rem_sh;
    uword_t       q_sh;
    logic         ge;
    uword_t       qq;

    always_comb
    begin
        rem_sh      = {rem_reg[62:0], dvd_reg[127]};
        ge          = (rem_sh >= d_reg);
        q_sh        = {q_reg[62:0], ge};
        qq          = over_reg ? uword_t'(CAP) : q_reg;
        busy_next   = busy_reg;
        fin_next    = fin_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        over_next   = over_reg;
        d_next      = d_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        if (req.start)
        begin
            dvd_next  = {64'd0, magn(req.a)} << req.shift;
            d_next    = req.b;
            neg_next  = req.a[63];
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[126:0], 1'b0};
            rem_next = ge ? (rem_sh - d_reg) : rem_sh;
            if (!over_reg)
            begin
                q_next = q_sh;
                if (q_sh > uword_t'(CAP))
                begin
                    over_next = 1'b1;
                end
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            result_next = neg_reg ? -word_t'(qq) : word_t'(qq);
            fin_next    = 1'b0;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        over_reg   <= over_next;
        d_reg      <= d_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

@@ rtl/bh_curve_hermite_reluctivity_top.sv @@
// ============================================================================
// bh_curve_hermite_reluctivity_top - B-H curve evaluator, reluctivity form
// Breakpoint table in RAM, segment scan and cubic Hermite interpolation.
// ============================================================================
// Usage. Requests arrive on the input channel (in_valid / in_stall) and each
// one produces exactly one result on the output channel (out_valid /
// out_stall). A load request writes one breakpoint into the table RAM and
// returns status "loaded" through the emit state. An evaluate request takes the
// magnitude of flux_density and returns the field strength, reluctivity and
// its derivative against b squared.
// A zero flux reads the first entry only; an empty table takes one product
// on the linear gain; extrapolation above the table takes one product and
// two quotients; flux below the table scans every entry; interpolation scans
// to the enclosing segment and then runs the full Hermite sequence.
// Every product runs on the shared bit-serial multiplier (64 steps) and every
// quotient on the restoring divider (128 steps); the segment scan reads one
// RAM entry per cycle. One request is worked on at a time, and the next can
// be taken in the cycle in which the result appears. The block takes a new
// request while the previous result still waits in the output register; it
// only holds a finished result back while out_stall is high and the previous
// result is still valid. Reset clears the configuration registers and the
// control state; the table RAM is not cleared and must be loaded before it
// is used. Configuration must be written through cfg_write / cfg_index /
// cfg_data only while the block is idle; the block itself does not enforce it.
// ============================================================================
`default_nettype none

module bh_curve_hermite_reluctivity_top
    import bhc_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [4:0]         entry_index,
    input  logic [30:0]        point_flux,
    input  logic signed [47:0] point_field,
    input  logic signed [47:0] point_slope,
    input  logic signed [31:0] flux_density,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] field_strength,
    output logic signed [47:0] reluctivity,
    output logic signed [47:0] reluctivity_derivative,
    output logic [2:0]         status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int EW = $bits(entry_t);

    // Fraction shifts: flux is Q.27, Hermite basis values are Q.30, and the
    // derivative divides by b squared, which needs 27 + 26 bits.
    localparam logic [5:0] SH_FLUX  = 6'd27;
    localparam logic [5:0] SH_BASIS = 6'd30;
    localparam logic [5:0] SH_SQ    = 6'd53;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b000_0001,
        S_CHK_ZERO = 7'b000_0010,
        S_CHK_LAST = 7'b000_0100,
        S_SCAN     = 7'b000_1000,
        S_ISSUE    = 7'b001_0000,
        S_WAIT     = 7'b010_0000,
        S_EMIT     = 7'b100_0000
    } state_t;

    // Arithmetic sequence of one evaluation.
    typedef enum logic [16:0] {
        P_LIN_H = 17'h00001,
        P_EXT   = 17'h00002,
        P_Z     = 17'h00004,
        P_Z2    = 17'h00008,
        P_Z3    = 17'h00010,
        P_LS0   = 17'h00020,
        P_LS1   = 17'h00040,
        P_H0    = 17'h00080,
        P_H1    = 17'h00100,
        P_H2    = 17'h00200,
        P_H3    = 17'h00400,
        P_T1M   = 17'h00800,
        P_T1D   = 17'h01000,
        P_DH0   = 17'h02000,
        P_DH1   = 17'h04000,
        P_V     = 17'h08000,
        P_DV    = 17'h10000
    } step_t;

    state_t         state_reg, state_next;
    step_t          step_reg, step_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [5:0]     table_points_reg, table_points_next;
    logic [47:0]    lin_reluct_reg, lin_reluct_next;
    logic [47:0]    lin_gain_reg, lin_gain_next;
    logic           out_valid_reg, out_valid_next;

    logic [31:0]    b_reg, b_next;
    logic [63:0]    bsq_reg, bsq_next;
    entry_t         seg0_reg, seg0_next;
    entry_t         seg1_reg, seg1_next;
    logic [30:0]    z_reg, z_next;
    logic [30:0]    z2_reg, z2_next;
    logic [30:0]    z3_reg, z3_next;
    word_t          ls0_reg, ls0_next;
    word_t          ls1_reg, ls1_next;
    word_t          h_reg, h_next;
    word_t          dh_reg, dh_next;
    word_t          t1_reg, t1_next;
    word_t          v_reg, v_next;
    word_t          dv_reg, dv_next;
    status_t        stat_reg, stat_next;
    q16_t           fs_reg, fs_next;
    q16_t           rel_reg, rel_next;
    q16_t           reld_reg, reld_next;
    logic [2:0]     stat_out_reg, stat_out_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    entry_t         ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_rdata;
    entry_t         rd;

    arith_req_t     mul_req, div_req;
    arith_rsp_t     mul_rsp, div_rsp;

    logic           in_accept;
    logic [NW-1:0]  n_pts;
    logic [NW-1:0]  n_m1;
    logic [AW-1:0]  last_addr;
    logic           ptr_last;
    logic [31:0]    k_wide;
    logic           k_ok;
    logic [30:0]    seg_len;
    word_t          len_w;
    word_t          b_minus_b0;
    word_t          b_minus_b1;
    word_t          zw, z2w, z3w;
    word_t          bas_h0, bas_h1, bas_h2, bas_h3, bas_t, bas_d0, bas_d1;
    word_t          dv_num;
    word_t          res;
    logic           found;

    bhc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bhc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    bhc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rd        = entry_t'(ram_rdata);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);

    // Effective table length: anything above the RAM depth acts as full.
    always_comb
    begin
        if (32'(table_points_reg) > MAX_POINTS)
        begin
            n_pts = NW'(MAX_POINTS);
        end
        else
        begin
            n_pts = NW'(table_points_reg);
        end
    end

    assign n_m1      = n_pts - NW'(1);
    assign last_addr = n_m1[AW-1:0];
    assign ptr_last  = (ptr_reg == last_addr);
    assign k_wide    = 32'(entry_index);
    assign k_ok      = (k_wide < MAX_POINTS);

    // Segment operands and Hermite basis values, all from registers.
    assign seg_len    = seg1_reg.flux - seg0_reg.flux;
    assign len_w      = word_t'({33'd0, seg_len});
    assign b_minus_b0 = word_t'({32'd0, b_reg}) - word_t'({33'd0, seg0_reg.flux});
    assign b_minus_b1 = word_t'({32'd0, b_reg}) - word_t'({33'd0, seg1_reg.flux});
    assign zw         = word_t'({33'd0, z_reg});
    assign z2w        = word_t'({33'd0, z2_reg});
    assign z3w        = word_t'({33'd0, z3_reg});
    assign bas_h0     = ONE - 64'sd3 * z2w + 64'sd2 * z3w;
    assign bas_h1     = zw - 64'sd2 * z2w + z3w;
    assign bas_h2     = 64'sd3 * z2w - 64'sd2 * z3w;
    assign bas_h3     = z3w - z2w;
    assign bas_t      = 64'sd6 * (zw - z2w);
    assign bas_d0     = ONE - 64'sd4 * zw + 64'sd3 * z2w;
    assign bas_d1     = 64'sd3 * z2w - 64'sd2 * zw;
    assign dv_num     = sadd(dh_reg, -v_reg);
    assign res        = mul_rsp.done ? mul_rsp.result : div_rsp.result;
    assign found      = (ptr_reg != '0)
                        && ({1'b0, seg1_reg.flux} <= b_reg)
                        && (b_reg <= {1'b0, rd.flux});

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        ptr_next          = ptr_reg;
        table_points_next = table_points_reg;
        lin_reluct_next   = lin_reluct_reg;
        lin_gain_next     = lin_gain_reg;
        out_valid_next    = out_valid_reg && out_stall;
        b_next            = b_reg;
        bsq_next          = bsq_reg;
        seg0_next         = seg0_reg;
        seg1_next         = seg1_reg;
        z_next            = z_reg;
        z2_next           = z2_reg;
        z3_next           = z3_reg;
        ls0_next          = ls0_reg;
        ls1_next          = ls1_reg;
        h_next            = h_reg;
        dh_next           = dh_reg;
        t1_next           = t1_reg;
        v_next            = v_reg;
        dv_next           = dv_reg;
        stat_next         = stat_reg;
        fs_next           = fs_reg;
        rel_next          = rel_reg;
        reld_next         = reld_reg;
        stat_out_next     = stat_out_reg;
        ram_we            = 1'b0;
        ram_waddr         = k_wide[AW-1:0];
        ram_wdata         = '{flux: point_flux, field: point_field, slope: point_slope};
        ram_raddr         = '0;
        mul_req           = '0;
        div_req           = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TABLE_POINTS: table_points_next = cfg_data[5:0];
                CFG_LIN_RELUCT:   lin_reluct_next   = cfg_data;
                CFG_LIN_GAIN:     lin_gain_next     = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    h_next  = '0;
                    v_next  = '0;
                    dv_next = '0;
                    dh_next = '0;
                    b_next  = flux_density[31] ? (~flux_density + 32'd1) : flux_density;
                    if (op == OP_LOAD)
                    begin
                        ram_we     = k_ok;
                        stat_next  = ST_LOADED;
                        state_next = S_EMIT;
                    end
                    else if (n_pts == '0)
                    begin
                        stat_next  = ST_LINEAR;
                        step_next  = P_LIN_H;
                        state_next = S_ISSUE;
                    end
                    else if (flux_density == '0)
                    begin
                        ram_raddr  = '0;
                        state_next = S_CHK_ZERO;
                    end
                    else
                    begin
                        ram_raddr  = last_addr;
                        state_next = S_CHK_LAST;
                    end
                end
            end

            S_CHK_ZERO:
            begin
                h_next     = (rd.flux == '0) ? word_t'(rd.field) : '0;
                v_next     = word_t'(rd.slope);
                dv_next    = '0;
                stat_next  = ST_ZERO;
                state_next = S_EMIT;
            end

            S_CHK_LAST:
            begin
                bsq_next = b_reg * b_reg;
                if (b_reg > {1'b0, rd.flux})
                begin
                    seg1_next  = rd;
                    stat_next  = ST_EXTRAP;
                    step_next  = P_EXT;
                    state_next = S_ISSUE;
                end
                else
                begin
                    ram_raddr  = '0;
                    ptr_next   = '0;
                    state_next = S_SCAN;
                end
            end

            // One entry per cycle; seg1 holds the entry before the one read.
            S_SCAN:
            begin
                seg1_next = rd;
                if (found)
                begin
                    seg0_next  = seg1_reg;
                    stat_next  = ST_INTERP;
                    step_next  = P_Z;
                    state_next = S_ISSUE;
                end
                else if (ptr_last)
                begin
                    stat_next  = ST_BELOW;
                    state_next = S_EMIT;
                end
                else
                begin
                    ptr_next  = ptr_reg + AW'(1);
                    ram_raddr = ptr_reg + AW'(1);
                end
            end

            S_ISSUE:
            begin
                state_next = S_WAIT;
                case (step_reg)
                    P_LIN_H:
                        mul_req = '{1'b1, word_t'({16'd0, lin_gain_reg}),
                                    uword_t'({32'd0, b_reg}), SH_FLUX};
                    P_EXT:
                        mul_req = '{1'b1, word_t'(seg1_reg.slope),
                                    uword_t'(b_minus_b1), SH_FLUX};
                    P_Z:
                    begin
                        if (seg_len == '0)
                        begin
                            z_next     = '0;
                            step_next  = P_Z2;
                            state_next = S_ISSUE;
                        end
                        else
                        begin
                            div_req = '{1'b1, b_minus_b0, uword_t'(len_w), SH_BASIS};
                        end
                    end
                    P_Z2:
                        mul_req = '{1'b1, zw, uword_t'(zw), SH_BASIS};
                    P_Z3:
                        mul_req = '{1'b1, z2w, uword_t'(zw), SH_BASIS};
                    P_LS0:
                        mul_req = '{1'b1, word_t'(seg0_reg.slope), uword_t'(len_w), SH_FLUX};
                    P_LS1:
                        mul_req = '{1'b1, word_t'(seg1_reg.slope), uword_t'(len_w), SH_FLUX};
                    P_H0:
                        mul_req = '{1'b1, word_t'(seg0_reg.field), uword_t'(bas_h0), SH_BASIS};
                    P_H1:
                        mul_req = '{1'b1, ls0_reg, uword_t'(bas_h1), SH_BASIS};
                    P_H2:
                        mul_req = '{1'b1, word_t'(seg1_reg.field), uword_t'(bas_h2), SH_BASIS};
                    P_H3:
                        mul_req = '{1'b1, ls1_reg, uword_t'(bas_h3), SH_BASIS};
                    P_T1M:
                    begin
                        // A zero-length segment drops the field-difference term.
                        if (seg_len == '0)
                        begin
                            t1_next    = '0;
                            step_next  = P_DH0;
                            state_next = S_ISSUE;
                        end
                        else
                        begin
                            mul_req = '{1'b1,
                                        word_t'(seg1_reg.field) - word_t'(seg0_reg.field),
                                        uword_t'(bas_t), SH_BASIS};
                        end
                    end
                    P_T1D:
                        div_req = '{1'b1, t1_reg, uword_t'(len_w), SH_FLUX};
                    P_DH0:
                        mul_req = '{1'b1, word_t'(seg0_reg.slope), uword_t'(bas_d0), SH_BASIS};
                    P_DH1:
                        mul_req = '{1'b1, word_t'(seg1_reg.slope), uword_t'(bas_d1), SH_BASIS};
                    P_V:
                        div_req = '{1'b1, h_reg, uword_t'({32'd0, b_reg}), SH_FLUX};
                    P_DV:
                        div_req = '{1'b1, dv_num, bsq_reg, SH_SQ};
                    default:
                        state_next = S_IDLE;
                endcase
            end

            S_WAIT:
            begin
                if (mul_rsp.done || div_rsp.done)
                begin
                    state_next = S_ISSUE;
                    case (step_reg)
                        P_LIN_H:
                        begin
                            h_next     = res;
                            v_next     = word_t'({16'd0, lin_reluct_reg});
                            dv_next    = '0;
                            state_next = S_EMIT;
                        end
                        P_EXT:
                        begin
                            h_next    = sadd(word_t'(seg1_reg.field), res);
                            dh_next   = word_t'(seg1_reg.slope);
                            step_next = P_V;
                        end
                        P_Z:
                        begin
                            z_next    = res[30:0];
                            step_next = P_Z2;
                        end
                        P_Z2:
                        begin
                            z2_next   = res[30:0];
                            step_next = P_Z3;
                        end
                        P_Z3:
                        begin
                            z3_next   = res[30:0];
                            step_next = P_LS0;
                        end
                        P_LS0:
                        begin
                            ls0_next  = res;
                            step_next = P_LS1;
                        end
                        P_LS1:
                        begin
                            ls1_next  = res;
                            step_next = P_H0;
                        end
                        P_H0:
                        begin
                            h_next    = res;
                            step_next = P_H1;
                        end
                        P_H1:
                        begin
                            h_next    = sadd(h_reg, res);
                            step_next = P_H2;
                        end
                        P_H2:
                        begin
                            h_next    = sadd(h_reg, res);
                            step_next = P_H3;
                        end
                        P_H3:
                        begin
                            h_next    = sadd(h_reg, res);
                            step_next = P_T1M;
                        end
                        P_T1M:
                        begin
                            t1_next   = res;
                            step_next = P_T1D;
                        end
                        P_T1D:
                        begin
                            t1_next   = res;
                            step_next = P_DH0;
                        end
                        P_DH0:
                        begin
                            dh_next   = sadd(t1_reg, res);
                            step_next = P_DH1;
                        end
                        P_DH1:
                        begin
                            dh_next   = sadd(dh_reg, res);
                            step_next = P_V;
                        end
                        P_V:
                        begin
                            v_next    = res;
                            step_next = P_DV;
                        end
                        P_DV:
                        begin
                            dv_next    = res;
                            state_next = S_EMIT;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fs_next        = out48(h_reg);
                    rel_next       = out48(v_reg);
                    reld_next      = out48(dv_reg);
                    stat_out_next  = stat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= P_LIN_H;
            ptr_reg          <= '0;
            table_points_reg <= '0;
            lin_reluct_reg   <= '0;
            lin_gain_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            ptr_reg          <= ptr_next;
            table_points_reg <= table_points_next;
            lin_reluct_reg   <= lin_reluct_next;
            lin_gain_reg     <= lin_gain_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        bsq_reg      <= bsq_next;
        seg0_reg     <= seg0_next;
        seg1_reg     <= seg1_next;
        z_reg        <= z_next;
        z2_reg       <= z2_next;
        z3_reg       <= z3_next;
        ls0_reg      <= ls0_next;
        ls1_reg      <= ls1_next;
        h_reg        <= h_next;
        dh_reg       <= dh_next;
        t1_reg       <= t1_next;
        v_reg        <= v_next;
        dv_reg       <= dv_next;
        stat_reg     <= stat_next;
        fs_reg       <= fs_next;
        rel_reg      <= rel_next;
        reld_reg     <= reld_next;
        stat_out_reg <= stat_out_next;
    end

    assign out_valid              = out_valid_reg;
    assign field_strength         = fs_reg;
    assign reluctivity            = rel_reg;
    assign reluctivity_derivative = reld_reg;
    assign status                 = stat_out_reg;

    // An accepted request always keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("request accepted while the block did not go busy");

    // The multiplier and the divider are never in use at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_rsp.done && div_rsp.done))
        else $error("multiplier and divider finished together");

    // A load result carries zero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_LOADED)) |->
            (field_strength == '0) && (reluctivity == '0)
            && (reluctivity_derivative == '0))
        else $error("load result with non-zero values");

    // A start request only leaves the issue state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mul_req.start || div_req.start) |-> (state_reg == S_ISSUE))
        else $error("arithmetic unit started outside the issue state");

endmodule

`default_nettype wire
